FILE: rtl/core/pidc_pkg.sv
// Shared types, constants and helpers of the clamped PID controller.
package pidc_pkg;

    // Default sample and fraction widths.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Gains are signed Q8.8 values.
    localparam int GAIN_BITS = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORM_SELECT = 3'd7;

    // Operand choice of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     iadd_en;
        logic     iclamp_en;
        logic     sum_en;
        logic     load_en;
    } pidc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic serial_form;
        logic out_free;
    } pidc_status_t;

    // Width of the configuration data bus: the widest register.
    function automatic int cfg_width(input int sample_bits);
        return (sample_bits > GAIN_BITS) ? sample_bits : GAIN_BITS;
    endfunction

endpackage

FILE: rtl/core/pidc_if.sv
// Valid/ready channel interfaces for samples and results.
interface pidc_sample_if import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] target;
    logic signed [SAMPLE_BITS-1:0] measured;
    logic                          clear_history;

    modport source (output valid, target, measured, clear_history, input ready);
    modport sink (input valid, target, measured, clear_history, output ready);
endinterface

interface pidc_result_if import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] drive;
    logic                          integ_clamped;
    logic                          drive_clamped;

    modport source (output valid, drive, integ_clamped, drive_clamped, input ready);
    modport sink (input valid, drive, integ_clamped, drive_clamped, output ready);
endinterface

FILE: rtl/core/pidc_ctrl.sv
// Sequencing state machine of the clamped PID controller.
module pidc_ctrl import pidc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_clear,
    output logic         in_ready,
    output pidc_cmd_t    cmd,
    input  pidc_status_t st
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PMUL   = 3'd1;
    localparam logic [2:0] ST_IMUL   = 3'd2;
    localparam logic [2:0] ST_IADD   = 3'd3;
    localparam logic [2:0] ST_ICLAMP = 3'd4;
    localparam logic [2:0] ST_DMUL   = 3'd5;
    localparam logic [2:0] ST_SUM    = 3'd6;
    localparam logic [2:0] ST_LOAD   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands for each step.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_sel = MUL_PROP;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = in_clear ? ST_LOAD : ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = ST_IMUL;
            end
            ST_IMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
                state_next  = ST_IADD;
            end
            ST_IADD:
            begin
                cmd.iadd_en = 1'b1;
                state_next  = ST_ICLAMP;
            end
            ST_ICLAMP:
            begin
                cmd.iclamp_en = 1'b1;
                state_next    = st.serial_form ? ST_SUM : ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Wait here until the output register can take the result.
                if (st.out_free)
                begin
                    cmd.load_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // A clearing transaction goes straight to the result load.
    a_clear_skips: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_clear |=> state_reg == ST_LOAD)
        else $error("clear transaction did not go to the load step");

    // A result is loaded only when the output register is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> st.out_free)
        else $error("result loaded while the output register is busy");

    // The serial form skips the derivative product.
    a_serial_skip: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ICLAMP && st.serial_form |=> state_reg == ST_SUM)
        else $error("serial form entered the derivative step");
`endif

endmodule

FILE: rtl/core/pidc_datapath.sv
// Datapath of the clamped PID controller: registers, shared multiplier, clamps.
module pidc_datapath import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [cfg_width(SAMPLE_BITS)-1:0]   cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       target,
    input  logic signed [SAMPLE_BITS-1:0]       measured,
    input  logic                                clear_history,
    input  pidc_cmd_t                           cmd,
    output pidc_status_t                        st,
    pidc_result_if.source                       result
);

    localparam int GB   = GAIN_BITS;
    localparam int EW   = SAMPLE_BITS + 1;          // error
    localparam int PW   = EW + GB;                  // proportional term
    localparam int DFW  = EW + 1;                   // error difference
    localparam int SATW = (PW > 48) ? PW : 48;      // saturation compare
    localparam int MOW  = (PW > 47) ? 48 : PW;      // multiplier data operand
    localparam int PRW  = MOW + GB;                 // product
    localparam int ISW  = PRW + 1;                  // integral sum
    localparam int IW   = SAMPLE_BITS + FRAC_BITS;  // clamped integral
    localparam int SW   = PRW + 2;                  // drive sum

    localparam logic signed [SATW-1:0] SAT_POS = SATW'(longint'(1) <<< 46);
    localparam logic signed [SATW-1:0] SAT_NEG = -SAT_POS;

    // Configuration registers.
    logic signed [GB-1:0]          prop_gain_reg;
    logic signed [GB-1:0]          integ_gain_reg;
    logic signed [GB-1:0]          deriv_gain_reg;
    logic signed [SAMPLE_BITS-1:0] integ_upper_reg;
    logic signed [SAMPLE_BITS-1:0] integ_lower_reg;
    logic signed [SAMPLE_BITS-1:0] drive_upper_reg;
    logic signed [SAMPLE_BITS-1:0] drive_lower_reg;
    logic                          form_select_reg;

    // Working and history registers.
    logic signed [EW-1:0]          err_reg;
    logic                          clr_reg;
    logic signed [PW-1:0]          p_reg;
    logic signed [PRW-1:0]         prod_reg;
    logic signed [ISW-1:0]         isum_reg;
    logic signed [IW-1:0]          integ_reg;
    logic signed [EW-1:0]          last_err_reg;
    logic                          ihit_reg;
    logic signed [SW-1:0]          sum_reg;

    // Output register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] drive_reg;
    logic                          iflag_reg;
    logic                          dflag_reg;

    logic signed [GB-1:0]   mul_a;
    logic signed [MOW-1:0]  mul_b;
    logic signed [PRW-1:0]  mul_prod;
    logic signed [SATW-1:0] p_wide;
    logic signed [MOW-1:0]  p_sat;
    logic signed [DFW-1:0]  err_diff;
    logic signed [PRW-1:0]  integ_term;
    logic signed [ISW-1:0]  integ_hi;
    logic signed [ISW-1:0]  integ_lo;
    logic signed [SW-1:0]   sum_full;
    logic signed [SW-1:0]   drive_hi;
    logic signed [SW-1:0]   drive_lo;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_upper_reg <= '0;
            integ_lower_reg <= '0;
            drive_upper_reg <= '0;
            drive_lower_reg <= '0;
            form_select_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GB-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GB-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GB-1:0];
                REG_INTEG_UPPER: integ_upper_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_INTEG_LOWER: integ_lower_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_DRIVE_UPPER: drive_upper_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_DRIVE_LOWER: drive_lower_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_FORM_SELECT: form_select_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Proportional term saturated for the serial integral product.
    assign p_wide = SATW'(p_reg);
    always_comb
    begin
        if (p_wide > SAT_POS)
        begin
            p_sat = MOW'(SAT_POS);
        end
        else if (p_wide < SAT_NEG)
        begin
            p_sat = MOW'(SAT_NEG);
        end
        else
        begin
            p_sat = MOW'(p_wide);
        end
    end

    assign err_diff = DFW'(err_reg) - DFW'(last_err_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_PROP:
            begin
                mul_a = prop_gain_reg;
                mul_b = MOW'(err_reg);
            end
            MUL_INTEG:
            begin
                mul_a = integ_gain_reg;
                mul_b = form_select_reg ? p_sat : MOW'(err_reg);
            end
            MUL_DERIV:
            begin
                mul_a = deriv_gain_reg;
                mul_b = MOW'(err_diff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = PRW'(mul_a) * PRW'(mul_b);

    // The serial integral step is floored to the fraction grid.
    assign integ_term = form_select_reg ? (prod_reg >>> FRAC_BITS) : prod_reg;

    assign integ_hi = ISW'(integ_upper_reg) <<< FRAC_BITS;
    assign integ_lo = ISW'(integ_lower_reg) <<< FRAC_BITS;

    // Sum of the terms; the derivative product only counts in parallel form.
    assign sum_full = SW'(p_reg) + SW'(integ_reg)
                    + (form_select_reg ? SW'(0) : SW'(prod_reg));

    assign drive_hi = SW'(drive_upper_reg);
    assign drive_lo = SW'(drive_lower_reg);

    // Per-transaction working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            err_reg <= EW'(target) - EW'(measured);
            clr_reg <= clear_history;
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_sel == MUL_PROP)
            begin
                p_reg <= PW'(mul_prod);
            end
            else
            begin
                prod_reg <= mul_prod;
            end
        end
        if (cmd.iadd_en)
        begin
            isum_reg <= ISW'(integ_reg) + ISW'(integ_term);
        end
        if (cmd.sum_en)
        begin
            sum_reg <= sum_full >>> FRAC_BITS;
        end
    end

    // Controller history: integral and previous error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
            ihit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.capture && clear_history)
            begin
                integ_reg    <= '0;
                last_err_reg <= '0;
            end
            else if (cmd.iclamp_en)
            begin
                // The upper test wins when the limits are crossed.
                if (isum_reg > integ_hi)
                begin
                    integ_reg <= IW'(integ_hi);
                    ihit_reg  <= 1'b1;
                end
                else if (isum_reg < integ_lo)
                begin
                    integ_reg <= IW'(integ_lo);
                    ihit_reg  <= 1'b1;
                end
                else
                begin
                    integ_reg <= IW'(isum_reg);
                    ihit_reg  <= 1'b0;
                end
            end
            else if (cmd.mul_en && cmd.mul_sel == MUL_DERIV)
            begin
                last_err_reg <= err_reg;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: drive clamp, or zeros for a clearing transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            if (clr_reg)
            begin
                drive_reg <= '0;
                iflag_reg <= 1'b0;
                dflag_reg <= 1'b0;
            end
            else
            begin
                iflag_reg <= ihit_reg;
                if (sum_reg > drive_hi)
                begin
                    drive_reg <= drive_upper_reg;
                    dflag_reg <= 1'b1;
                end
                else if (sum_reg < drive_lo)
                begin
                    drive_reg <= drive_lower_reg;
                    dflag_reg <= 1'b1;
                end
                else
                begin
                    drive_reg <= SAMPLE_BITS'(sum_reg);
                    dflag_reg <= 1'b0;
                end
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.drive         = drive_reg;
    assign result.integ_clamped = iflag_reg;
    assign result.drive_clamped = dflag_reg;

    assign st.serial_form = form_select_reg;
    assign st.out_free    = !out_valid_reg || result.ready;

`ifndef SYNTHESIS
    // A clearing transaction zeroes the history at once.
    a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && clear_history |=> integ_reg == '0 && last_err_reg == '0)
        else $error("history not cleared");

    // With ordered limits the clamped integral lies between them.
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.iclamp_en) && (integ_upper_reg >= integ_lower_reg)
        |-> (ISW'(integ_reg) <= integ_hi) && (ISW'(integ_reg) >= integ_lo))
        else $error("integral outside its limits after the clamp");

    // A loaded result is presented in the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |=> result.valid)
        else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/core/pid_controller_clamped_unit.sv
// Top level of the clamped PID controller: controller and datapath.
//
// One transaction on the sample channel gives one transaction on the result
// channel. A normal sample runs the proportional product, integral product,
// integral add and clamp, derivative product (parallel form only), drive sum
// and load steps; a clearing sample goes straight to the load step, which
// waits for a free output register. The single shared multiplier forms the
// products one after another. The result sits in an output register, so a
// new sample is accepted while the previous result still waits to be taken.
// The user must write configuration registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
module pid_controller_clamped_unit import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    pidc_sample_if.sink                       sample,
    pidc_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [cfg_width(SAMPLE_BITS)-1:0] cfg_data
);

    pidc_cmd_t    cmd;
    pidc_status_t st;
    logic         in_ready;

    // Sequencer.
    pidc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_clear (sample.clear_history),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    assign sample.ready = in_ready;

    // Arithmetic, state and output register.
    pidc_datapath
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target        (sample.target),
        .measured      (sample.measured),
        .clear_history (sample.clear_history),
        .cmd           (cmd),
        .st            (st),
        .result        (result)
    );

endmodule
